[rtl/md5bc_pkg.sv]
// ----------------------------------------------------------------------------
// md5bc_pkg
// Types, constants and round functions shared by the MD5 compression block.
// ----------------------------------------------------------------------------
package md5bc_pkg;

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;

   localparam logic [1:0] PHASE_F = 2'd0;
   localparam logic [1:0] PHASE_G = 2'd1;
   localparam logic [1:0] PHASE_H = 2'd2;
   localparam logic [1:0] PHASE_I = 2'd3;

   typedef struct packed {
      logic       word_we;
      logic [3:0] word_idx;
      logic       load_iv;
      logic       start;
      logic       round_en;
      logic [5:0] round_idx;
      logic       finish;
      logic [1:0] out_idx;
   } cmd_type;

   function automatic logic [31:0] sine_const(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0:  k = 32'hd76aa478;
         6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;
         6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;
         6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;
         6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;
         6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;
         6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;
         6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;
         6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;
         6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;
         6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;
         6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;
         6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;
         6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;
         6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;
         6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;
         6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;
         6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;
         6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;
         6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;
         6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;
         6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;
         6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;
         6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;
         6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;
         6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;
         6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;
         6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;
         6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;
         6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;
         6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;
         6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;
         default: k = 32'heb86d391;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] shift_amount(input logic [5:0] i);
      logic [4:0] s;
      case ({i[5:4], i[1:0]})
         4'd0:  s = 5'd7;
         4'd1:  s = 5'd12;
         4'd2:  s = 5'd17;
         4'd3:  s = 5'd22;
         4'd4:  s = 5'd5;
         4'd5:  s = 5'd9;
         4'd6:  s = 5'd14;
         4'd7:  s = 5'd20;
         4'd8:  s = 5'd4;
         4'd9:  s = 5'd11;
         4'd10: s = 5'd16;
         4'd11: s = 5'd23;
         4'd12: s = 5'd6;
         4'd13: s = 5'd10;
         4'd14: s = 5'd15;
         default: s = 5'd21;
      endcase
      return s;
   endfunction

   function automatic logic [3:0] msg_index(input logic [5:0] i);
      logic [3:0] r;
      case (i[5:4])
         PHASE_F: r = i[3:0];
         PHASE_G: r = 4'(i[3:0] * 4'd5 + 4'd1);
         PHASE_H: r = 4'(i[3:0] * 4'd3 + 4'd5);
         PHASE_I: r = 4'(i[3:0] * 4'd7);
         default: r = i[3:0];
      endcase
      return r;
   endfunction

   function automatic logic [31:0] round_fn(input logic [1:0] phase, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      case (phase)
         PHASE_F: f = (b & c) | (~b & d);
         PHASE_G: f = (b & d) | (c & ~d);
         PHASE_H: f = b ^ c ^ d;
         PHASE_I: f = c ^ (b | ~d);
         default: f = b ^ c ^ d;
      endcase
      return f;
   endfunction

   function automatic logic [31:0] swap_bytes(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

[rtl/md5bc_ctrl.sv]
// ----------------------------------------------------------------------------
// md5bc_ctrl
// Sequencer: word loading, 64 round steps, chain update and digest readout.
// ----------------------------------------------------------------------------
module md5bc_ctrl
   import md5bc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_new_message,
   output logic    req_stall,
   output logic    rsp_valid,
   output logic    rsp_digest_last,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   localparam logic [1:0] ST_LOAD   = 2'd0;
   localparam logic [1:0] ST_ROUND  = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [3:0] word_count_ff, word_count_in;
   logic [5:0] round_ff, round_in;
   logic       out_busy_ff, out_busy_in;
   logic [1:0] out_idx_ff, out_idx_in;

   logic req_accept;
   logic rsp_accept;
   logic finish;

   assign req_stall  = (state_ff != ST_LOAD);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = out_busy_ff;
   assign rsp_accept = out_busy_ff && !rsp_stall;
   assign rsp_digest_last = (out_idx_ff == 2'd3);
   assign finish = (state_ff == ST_FINISH) && !out_busy_ff;

   always_comb begin
      cmd.word_we   = req_accept;
      cmd.word_idx  = word_count_ff;
      cmd.load_iv   = req_accept && (word_count_ff == 4'd0) && req_new_message;
      cmd.start     = req_accept && (word_count_ff == 4'd15);
      cmd.round_en  = (state_ff == ST_ROUND);
      cmd.round_idx = round_ff;
      cmd.finish    = finish;
      cmd.out_idx   = out_idx_ff;
   end

   always_comb begin
      state_in      = state_ff;
      word_count_in = word_count_ff;
      round_in      = round_ff;
      out_busy_in   = out_busy_ff;
      out_idx_in    = out_idx_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               word_count_in = word_count_ff + 4'd1;
               if (word_count_ff == 4'd15) begin
                  state_in = ST_ROUND;
                  round_in = 6'd0;
               end
            end
         end
         ST_ROUND: begin
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
      if (rsp_accept) begin
         out_idx_in = out_idx_ff + 2'd1;
         if (out_idx_ff == 2'd3) begin
            out_busy_in = 1'b0;
         end
      end
      if (finish) begin
         out_busy_in = 1'b1;
         out_idx_in  = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         word_count_ff <= 4'd0;
         round_ff      <= 6'd0;
         out_busy_ff   <= 1'b0;
         out_idx_ff    <= 2'd0;
      end else begin
         state_ff      <= state_in;
         word_count_ff <= word_count_in;
         round_ff      <= round_in;
         out_busy_ff   <= out_busy_in;
         out_idx_ff    <= out_idx_in;
      end
   end

endmodule

[rtl/md5bc_datapath.sv]
// ----------------------------------------------------------------------------
// md5bc_datapath
// Block buffer, working registers a-d, one MD5 step per cycle, chain and
// digest output registers.
// ----------------------------------------------------------------------------
module md5bc_datapath
   import md5bc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic [31:0] req_msg_word,
   output logic [31:0] rsp_digest_word
);

   logic [31:0] block_ff [16];
   logic [31:0] chain_ff [4];
   logic [31:0] work_ff  [4];
   logic [31:0] digest_ff [4];

   logic [1:0]  phase;
   logic [31:0] fn;
   logic [31:0] step_sum;
   logic [63:0] rot_wide;
   logic [31:0] new_b;
   logic [31:0] chain_sum [4];

   assign phase    = cmd.round_idx[5:4];
   assign fn       = round_fn(phase, work_ff[1], work_ff[2], work_ff[3]);
   assign step_sum = work_ff[0] + fn + sine_const(cmd.round_idx)
                     + block_ff[msg_index(cmd.round_idx)];
   assign rot_wide = {step_sum, step_sum} << shift_amount(cmd.round_idx);
   assign new_b    = work_ff[1] + rot_wide[63:32];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         chain_sum[k] = chain_ff[k] + work_ff[k];
      end
   end

   assign rsp_digest_word = digest_ff[cmd.out_idx];

   always_ff @(posedge clock) begin
      if (cmd.word_we) begin
         block_ff[cmd.word_idx] <= req_msg_word;
      end
      if (cmd.finish) begin
         for (int k = 0; k < 4; k++) begin
            digest_ff[k] <= swap_bytes(chain_sum[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff[0] <= IV_A;
         chain_ff[1] <= IV_B;
         chain_ff[2] <= IV_C;
         chain_ff[3] <= IV_D;
         for (int k = 0; k < 4; k++) begin
            work_ff[k] <= 32'd0;
         end
      end else begin
         if (cmd.load_iv) begin
            chain_ff[0] <= IV_A;
            chain_ff[1] <= IV_B;
            chain_ff[2] <= IV_C;
            chain_ff[3] <= IV_D;
         end else if (cmd.finish) begin
            for (int k = 0; k < 4; k++) begin
               chain_ff[k] <= chain_sum[k];
            end
         end
         if (cmd.start) begin
            for (int k = 0; k < 4; k++) begin
               work_ff[k] <= chain_ff[k];
            end
         end else if (cmd.round_en) begin
            // a <= d, b <= b + rot, c <= b, d <= c
            work_ff[0] <= work_ff[3];
            work_ff[1] <= new_b;
            work_ff[2] <= work_ff[1];
            work_ff[3] <= work_ff[2];
         end
      end
   end

endmodule

[rtl/md5_block_compress.sv]
// ----------------------------------------------------------------------------
// md5_block_compress
// MD5 compression over a stream of padded 32-bit little-endian message words.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one message word per transfer, sixteen per 512-bit block.
//   req_new_message on a block's first word restarts the chain from the
//   standard initial values; elsewhere it is ignored.
//   rsp_* returns four words per block: chain a, b, c, d, byte-reversed;
//   rsp_digest_last marks d.
// Timing:
//   Words are taken one per cycle while req_stall is low. After the sixteenth
//   word the block stalls req_ through the round steps (one MD5 step per cycle
//   in a single round unit) and the chain add. The first digest word is valid
//   once the chain add has filled the digest output registers.
//   The digest sits in its own output registers, so the next block loads
//   while the previous digest drains.
// Stall: a stalled rsp_ holds its word; if the previous digest has not been
//   taken when the next block finishes, the chain add waits for it.
// Reset: synchronous; chain returns to the initial values, no words pending.
// ----------------------------------------------------------------------------
module md5_block_compress
   import md5bc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_msg_word,
   input  logic        req_new_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic        rsp_digest_last
);

   cmd_type cmd;

   md5bc_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_new_message (req_new_message),
      .req_stall       (req_stall),
      .rsp_valid       (rsp_valid),
      .rsp_digest_last (rsp_digest_last),
      .rsp_stall       (rsp_stall),
      .cmd             (cmd)
   );

   md5bc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_msg_word    (req_msg_word),
      .rsp_digest_word (rsp_digest_word)
   );

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (cmd.round_en && cmd.round_idx == 6'd0))
      else $error("round sequence did not begin after last word");

   a_finish_loads_out: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (rsp_valid && !rsp_digest_last))
      else $error("digest not presented after chain update");

   a_finish_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !rsp_valid)
      else $error("chain update overwrote an undelivered digest");

   a_no_load_in_rounds: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !cmd.round_en)
      else $error("word accepted during round steps");

endmodule
